// ===== design/avfx_pkg.sv =====
// Package for the affine vertex transform core: value widths, operation codes,
// record word layout and the transaction structs shared by all modules.
// No dependencies.
`default_nettype none

package avfx_pkg;

  // Width of every stored and transferred value (signed fixed point).
  localparam int VALUE_WIDTH   = 32;
  localparam int FRACTION_DEF  = 16;
  localparam int PROD_WIDTH    = 2 * VALUE_WIDTH;
  localparam int SUM_WIDTH     = PROD_WIDTH + 2;
  localparam int TOTAL_WIDTH   = SUM_WIDTH + 1;

  localparam int OP_WIDTH      = 3;
  localparam int INDEX_WIDTH   = 5;

  // Layout of the affine record.
  localparam int RECORD_WORDS  = 24;
  localparam int FWD_BASE      = 0;
  localparam int INV_BASE      = 9;
  localparam int FWD_TR_BASE   = 18;
  localparam int INV_TR_BASE   = 21;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;

  localparam value_t VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam value_t VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  typedef enum logic [OP_WIDTH-1:0] {
    OP_LOAD   = 3'd0,
    OP_FWD    = 3'd1,
    OP_INV    = 3'd2,
    OP_NORMAL = 3'd3,
    OP_DIR    = 3'd4
  } op_e;

  typedef struct packed {
    logic [OP_WIDTH-1:0]    operation;
    logic [INDEX_WIDTH-1:0] word_index;
    value_t                 word_value;
    value_t                 x_in;
    value_t                 y_in;
    value_t                 z_in;
  } in_item_t;

  typedef struct packed {
    value_t x_out;
    value_t y_out;
    value_t z_out;
    logic   saturated;
  } out_item_t;

  // Work handed from the front to the back: the selected 3x3 coefficients
  // (row-major), the translation and the point.
  typedef struct packed {
    value_t [8:0] coef;
    value_t [2:0] trans;
    value_t [2:0] point;
  } cmd_t;

endpackage

`default_nettype wire

// ===== design/affine_vertex_transform_core.sv =====
// Top level of the affine vertex transform core.
// Instantiates avfx_front, avfx_queue and avfx_back; depends on avfx_pkg.
//
// Usage: the block looks like a queue on both sides. A transaction is written
// by raising push with a payload on in_item_i while full is low. Results are
// read from out_item_o while empty is low and taken by raising pop.
// A load transaction (operation 0) writes one word of the affine record at
// the accepting edge and yields no result; a later transform always sees it.
// Transform transactions (operations 1 to 4) each yield exactly one result,
// in the order of acceptance. Unknown operations and loads to words 24 to 31
// are accepted and have no effect.
// An accepted transform passes the front queue, the product stage, the sum stage
// and the result register. Throughput is one transaction per cycle while nothing
// stalls; the nine 32x32 multipliers work in parallel and are fully pipelined.
// When the receiver stops popping, the result register and the two pipeline
// stages hold their data, then the two-entry front queue fills and full rises.
// Loads are still taken only while full is low.
// Reset (rst_ni low) empties all stages and restores the record to identity
// matrices with zero translations.
`default_nettype none

module affine_vertex_transform_core #(
  parameter int FRACTION_BITS = avfx_pkg::FRACTION_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push,
  output logic                     full,
  input  wire avfx_pkg::in_item_t  in_item_i,
  output logic                     empty,
  input  wire logic                pop,
  output avfx_pkg::out_item_t      out_item_o
);
  import avfx_pkg::*;

  logic q_push;
  cmd_t q_cmd_in;
  logic q_full;
  logic q_valid;
  cmd_t q_cmd_out;
  logic q_pop;

  // The front only stalls on a full queue; that is also the input full flag.
  assign full = q_full;

  avfx_front #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (in_item_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_cmd_o  (q_cmd_in)
  );

  avfx_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_cmd_in),
    .full_o  (q_full),
    .valid_o (q_valid),
    .cmd_o   (q_cmd_out),
    .pop_i   (q_pop)
  );

  avfx_back #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .cmd_i   (q_cmd_out),
    .pop_o   (q_pop),
    .empty_o (empty),
    .item_o  (out_item_o),
    .pop_i   (pop)
  );

endmodule

`default_nettype wire

// ===== design/avfx_front.sv =====
// Front end of the affine vertex transform core: holds the affine record,
// executes loads and selects coefficients for transform transactions.
// Depends on avfx_pkg.
`default_nettype none

module avfx_front #(
  parameter int FRACTION_BITS = avfx_pkg::FRACTION_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire avfx_pkg::in_item_t item_i,
  input  wire logic              q_full_i,
  output logic                   q_push_o,
  output avfx_pkg::cmd_t         q_cmd_o
);
  import avfx_pkg::*;

  localparam value_t ONE = value_t'(1) << FRACTION_BITS;

  value_t record_q [RECORD_WORDS];
  logic   accept;
  logic   is_xform;

  assign accept   = push_i && !q_full_i;
  assign is_xform = (item_i.operation == OP_FWD) || (item_i.operation == OP_INV) ||
                    (item_i.operation == OP_NORMAL) || (item_i.operation == OP_DIR);
  assign q_push_o = accept && is_xform;

  // Both matrices come out of reset as identity, both translations as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < RECORD_WORDS; i++) begin
        if (i == FWD_BASE + 0 || i == FWD_BASE + 4 || i == FWD_BASE + 8 ||
            i == INV_BASE + 0 || i == INV_BASE + 4 || i == INV_BASE + 8) begin
          record_q[i] <= ONE;
        end else begin
          record_q[i] <= '0;
        end
      end
    end else if (accept && item_i.operation == OP_LOAD &&
                 item_i.word_index < INDEX_WIDTH'(RECORD_WORDS)) begin
      record_q[item_i.word_index] <= item_i.word_value;
    end
  end

  // Each coefficient slot chooses among at most four fixed record words; a diagonal slot among two.
  always_comb begin
    q_cmd_o.point[0] = item_i.x_in;
    q_cmd_o.point[1] = item_i.y_in;
    q_cmd_o.point[2] = item_i.z_in;
    for (int k = 0; k < 9; k++) begin
      case (op_e'(item_i.operation))
        OP_FWD:    q_cmd_o.coef[k] = record_q[FWD_BASE + k];
        OP_INV:    q_cmd_o.coef[k] = record_q[INV_BASE + k];
        OP_NORMAL: q_cmd_o.coef[k] = record_q[INV_BASE + (k % 3) * 3 + k / 3];
        default:   q_cmd_o.coef[k] = record_q[FWD_BASE + (k % 3) * 3 + k / 3];
      endcase
    end
    for (int k = 0; k < 3; k++) begin
      case (op_e'(item_i.operation))
        OP_FWD:  q_cmd_o.trans[k] = record_q[FWD_TR_BASE + k];
        OP_INV:  q_cmd_o.trans[k] = record_q[INV_TR_BASE + k];
        default: q_cmd_o.trans[k] = '0;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/avfx_queue.sv =====
// Two-entry queue between the front and the back of the affine vertex
// transform core. Depends on avfx_pkg.
`default_nettype none

module avfx_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire avfx_pkg::cmd_t cmd_i,
  output logic                full_o,
  output logic                valid_o,
  output avfx_pkg::cmd_t      cmd_o,
  input  wire logic           pop_i
);
  import avfx_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

// ===== design/avfx_back.sv =====
// Back end of the affine vertex transform core: nine multipliers, a summing
// stage and a shift, translate and saturate stage feeding the result register.
// Depends on avfx_pkg.
`default_nettype none

module avfx_back #(
  parameter int FRACTION_BITS = avfx_pkg::FRACTION_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  input  wire avfx_pkg::cmd_t    cmd_i,
  output logic                   pop_o,
  output logic                   empty_o,
  output avfx_pkg::out_item_t    item_o,
  input  wire logic              pop_i
);
  import avfx_pkg::*;

  typedef logic signed [PROD_WIDTH-1:0]  prod_t;
  typedef logic signed [SUM_WIDTH-1:0]   sum_t;
  typedef logic signed [TOTAL_WIDTH-1:0] total_t;

  // Stage 1: products.
  logic         s1_v_q;
  prod_t        prod_q [9];
  prod_t        prod_d [9];
  value_t [2:0] s1_trans_q;
  // Stage 2: exact sums.
  logic         s2_v_q;
  sum_t         sum_q [3];
  sum_t         sum_d [3];
  value_t [2:0] s2_trans_q;
  // Stage 3: result register.
  logic         out_v_q;
  out_item_t    out_q, out_d;

  logic s1_ready, s2_ready, s3_ready;

  assign s3_ready = !out_v_q || pop_i;
  assign s2_ready = !s2_v_q || s3_ready;
  assign s1_ready = !s1_v_q || s2_ready;
  assign pop_o    = s1_ready;

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      prod_d[k] = prod_t'($signed(cmd_i.coef[k])) * prod_t'($signed(cmd_i.point[k % 3]));
    end
    for (int j = 0; j < 3; j++) begin
      sum_d[j] = sum_t'(prod_q[3*j]) + sum_t'(prod_q[3*j+1]) + sum_t'(prod_q[3*j+2]);
    end
  end

  // Floor shift, add translation, then clamp each component to the value range.
  always_comb begin
    total_t tot [3];
    sum_t   shifted;
    value_t comp [3];
    logic   sat [3];
    for (int j = 0; j < 3; j++) begin
      shifted = sum_q[j] >>> FRACTION_BITS;
      tot[j]  = total_t'(shifted) + total_t'($signed(s2_trans_q[j]));
      sat[j]  = !((&tot[j][TOTAL_WIDTH-1:VALUE_WIDTH-1]) ||
                  !(|tot[j][TOTAL_WIDTH-1:VALUE_WIDTH-1]));
      if (sat[j]) begin
        comp[j] = tot[j][TOTAL_WIDTH-1] ? VALUE_MIN : VALUE_MAX;
      end else begin
        comp[j] = tot[j][VALUE_WIDTH-1:0];
      end
    end
    out_d.x_out     = comp[0];
    out_d.y_out     = comp[1];
    out_d.z_out     = comp[2];
    out_d.saturated = sat[0] || sat[1] || sat[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v_q <= valid_i;
      end
      if (s2_ready) begin
        s2_v_q <= s1_v_q;
      end
      if (s3_ready) begin
        out_v_q <= s2_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && valid_i) begin
      prod_q     <= prod_d;
      s1_trans_q <= cmd_i.trans;
    end
    if (s2_ready && s1_v_q) begin
      sum_q      <= sum_d;
      s2_trans_q <= s1_trans_q;
    end
    if (s3_ready && s2_v_q) begin
      out_q <= out_d;
    end
  end

  assign empty_o = !out_v_q;
  assign item_o  = out_q;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for affine_vertex_transform_core.
// Drives load and transform transactions through the push/full queue port and checks every
// popped result against an in-bench Q16.16 predictor of the affine record. Depends on avfx_pkg.

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import avfx_pkg::*;

  localparam int HALF_PERIOD    = 10;
  localparam int RESET_CYCLES   = 10;
  localparam int PHASES         = 5;
  localparam int PHASE_ITEMS    = 310;
  // The longest legal quiet stretch is a long send gap followed by a long pop gap
  // plus the pipeline; this limit is many times that.
  localparam int WATCHDOG_LIMIT = 2000;
  // Wait on at the end so that a stray extra result would still be caught.
  localparam int DRAIN_CYCLES   = 16;
  localparam int ACC_WIDTH      = 2 * VALUE_WIDTH + 8;

  // Operation codes that the core accepts and drops.
  localparam logic [OP_WIDTH-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [OP_WIDTH-1:0] OP_SPARE_LAST  = 3'd7;
  localparam logic [INDEX_WIDTH-1:0] INDEX_TOP   = {INDEX_WIDTH{1'b1}};

  localparam value_t ONE = value_t'(1 << FRACTION_DEF);

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      push;
  logic      full;
  in_item_t  in_item_i;
  logic      empty;
  logic      pop;
  out_item_t out_item_o;

  // Transactions waiting to be offered, and the results the predictor expects, oldest first.
  in_item_t  pending_items[$];
  out_item_t expected_results[$];
  out_item_t oldest_result;

  // The predictor's copy of the affine record.
  value_t    affine_words[RECORD_WORDS];

  bit        item_taken;
  bit        push_idle_on;
  bit        pop_idle_on;
  int        push_gap;
  int        pop_gap;
  int        idle_cycles;
  int        error_count;
  int        load_count;
  int        transform_count;
  int        ignored_count;
  int        clamped_count;

  affine_vertex_transform_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item_i),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

  always begin
    #HALF_PERIOD clk_i = 1'b1;
    #HALF_PERIOD clk_i = 1'b0;
  end

  // Predicts one transform. The three products of a component are summed at full width,
  // shifted right arithmetically (so the fraction is floored), the translation is added,
  // and the total is clamped to the value range with the saturated flag raised.
  function automatic out_item_t transform_point(in_item_t item);
    value_t                  coef[9];
    value_t                  offset[3];
    value_t                  point[3];
    value_t                  comp[3];
    logic signed [ACC_WIDTH-1:0] acc, lhs, rhs, lim_hi, lim_lo;
    int                      r, c, k, sel;
    out_item_t               res;
    lim_hi = VALUE_MAX;
    lim_lo = VALUE_MIN;
    point[0] = item.x_in;
    point[1] = item.y_in;
    point[2] = item.z_in;
    for (k = 0; k < 9; k++) begin
      r = k / 3;
      c = k % 3;
      case (item.operation)
        OP_FWD:    sel = FWD_BASE + k;
        OP_INV:    sel = INV_BASE + k;
        // Normals use the transpose of the inverse matrix.
        OP_NORMAL: sel = INV_BASE + c * 3 + r;
        // Directions use the transpose of the forward matrix.
        default:   sel = FWD_BASE + c * 3 + r;
      endcase
      coef[k] = affine_words[sel];
    end
    for (k = 0; k < 3; k++) begin
      case (item.operation)
        OP_FWD:  offset[k] = affine_words[FWD_TR_BASE + k];
        OP_INV:  offset[k] = affine_words[INV_TR_BASE + k];
        default: offset[k] = '0;
      endcase
    end
    res.saturated = 1'b0;
    for (r = 0; r < 3; r++) begin
      acc = '0;
      for (c = 0; c < 3; c++) begin
        lhs = coef[r * 3 + c];
        rhs = point[c];
        acc = acc + lhs * rhs;
      end
      acc = acc >>> FRACTION_DEF;
      lhs = offset[r];
      acc = acc + lhs;
      if (acc > lim_hi) begin
        comp[r] = VALUE_MAX;
        res.saturated = 1'b1;
      end else if (acc < lim_lo) begin
        comp[r] = VALUE_MIN;
        res.saturated = 1'b1;
      end else begin
        comp[r] = acc[VALUE_WIDTH-1:0];
      end
    end
    res.x_out = comp[0];
    res.y_out = comp[1];
    res.z_out = comp[2];
    return res;
  endfunction

  // Values are mostly small Q16.16 numbers in [-4, 4]; the rest are extremes or raw
  // 32-bit patterns. wide_pct sets how often the latter appear.
  function automatic value_t rand_value(int wide_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < wide_pct / 4) return VALUE_MAX;
    if (roll < wide_pct / 2) return VALUE_MIN;
    if (roll < wide_pct) return value_t'($urandom);
    return value_t'($urandom_range(0, 8 * ONE)) - 4 * ONE;
  endfunction

  // Fields that an operation does not use are filled with noise.
  function automatic in_item_t make_point(logic [OP_WIDTH-1:0] op, value_t x, value_t y,
                                          value_t z);
    in_item_t item;
    item.operation  = op;
    item.word_index = INDEX_WIDTH'($urandom);
    item.word_value = value_t'($urandom);
    item.x_in       = x;
    item.y_in       = y;
    item.z_in       = z;
    return item;
  endfunction

  function automatic in_item_t make_load(int idx, value_t v);
    in_item_t item;
    item            = make_point(OP_LOAD, value_t'($urandom), value_t'($urandom),
                                 value_t'($urandom));
    item.word_index = INDEX_WIDTH'(idx);
    item.word_value = v;
    return item;
  endfunction

  function automatic in_item_t random_item();
    int roll;
    int idx;
    roll = $urandom_range(0, 99);
    if (roll < 25) begin
      // One load in ten targets a word past the end of the record.
      idx = ($urandom_range(0, 9) == 0) ? $urandom_range(RECORD_WORDS, INDEX_TOP)
                                        : $urandom_range(0, RECORD_WORDS - 1);
      return make_load(idx, rand_value(10));
    end
    if (roll < 30)
      return make_point(OP_WIDTH'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)),
                        rand_value(50), rand_value(50), rand_value(50));
    return make_point(OP_WIDTH'($urandom_range(OP_FWD, OP_DIR)),
                      rand_value(20), rand_value(20), rand_value(20));
  endfunction

  // Most idle stretches are a few cycles; about one in five is long.
  function automatic int idle_span();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic check_field(string name, logic [VALUE_WIDTH-1:0] want,
                             logic [VALUE_WIDTH-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %h, actual %h", name, want, got);
      error_count++;
    end
  endtask

  // Sender waits until every queued transaction is accepted, then until every
  // expected result has been popped.
  task automatic drain_all();
    while (pending_items.size() != 0 || push) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // Driver: inputs change only at the falling edge. A transaction stays on the port
  // until the monitor has seen it accepted; after acceptance an idle gap may follow.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!push || item_taken) begin
        if (push_gap > 0) begin
          push_gap--;
          push <= 1'b0;
        end else if (pending_items.size() > 0) begin
          push      <= 1'b1;
          in_item_i <= pending_items.pop_front();
          if (push_idle_on && $urandom_range(0, 3) == 0) push_gap = idle_span();
        end else begin
          push <= 1'b0;
        end
      end
      item_taken = 1'b0;
      // The receiver stalls at random, independent of whether a result is waiting.
      if (pop_gap > 0) begin
        pop_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        if (pop_idle_on && $urandom_range(0, 3) == 0) pop_gap = idle_span();
      end
    end
  end

  // Monitor: samples both handshakes at the rising edge. A popped result is checked
  // against the oldest expectation; an accepted transaction updates the predictor's
  // record (loads) or queues its expected result (transforms), in acceptance order.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      idle_cycles++;
      if (pop && !empty) begin
        idle_cycles = 0;
        if (expected_results.size() == 0) begin
          $error("result transaction with no transform outstanding: %h", out_item_o);
          error_count++;
        end else begin
          oldest_result = expected_results.pop_front();
          check_field("x_out", oldest_result.x_out, out_item_o.x_out);
          check_field("y_out", oldest_result.y_out, out_item_o.y_out);
          check_field("z_out", oldest_result.z_out, out_item_o.z_out);
          check_field("saturated", VALUE_WIDTH'(oldest_result.saturated),
                      VALUE_WIDTH'(out_item_o.saturated));
          if (oldest_result.saturated) clamped_count++;
        end
      end
      if (push && !full) begin
        idle_cycles = 0;
        item_taken  = 1'b1;
        case (in_item_i.operation)
          OP_LOAD: begin
            if (in_item_i.word_index < RECORD_WORDS) begin
              affine_words[in_item_i.word_index] = in_item_i.word_value;
              load_count++;
            end else begin
              ignored_count++;
            end
          end
          OP_FWD, OP_INV, OP_NORMAL, OP_DIR: begin
            expected_results.push_back(transform_point(in_item_i));
            transform_count++;
          end
          default: ignored_count++;
        endcase
      end
    end
  end

  // Watchdog: ends the run if no transaction of either kind completes for too long.
  initial begin : watchdog
    do @(posedge clk_i); while (idle_cycles < WATCHDOG_LIMIT);
    $error("no transaction accepted for %0d cycles", WATCHDOG_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    int k;
    int phase;
    rst_ni       = 1'b0;
    push         = 1'b0;
    pop          = 1'b0;
    in_item_i    = '0;
    push_idle_on = 1'b1;
    pop_idle_on  = 1'b1;

    // The record comes out of reset as identity matrices with zero translations.
    for (k = 0; k < RECORD_WORDS; k++) affine_words[k] = '0;
    for (k = 0; k < 3; k++) begin
      affine_words[FWD_BASE + 4 * k] = ONE;
      affine_words[INV_BASE + 4 * k] = ONE;
    end

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. First all four modes on the reset record, including the
    // extremes of the point range and the smallest negative fraction.
    pending_items.push_back(make_point(OP_FWD, ONE, 2 * ONE, -3 * ONE));
    pending_items.push_back(make_point(OP_INV, VALUE_MAX, VALUE_MIN, '0));
    pending_items.push_back(make_point(OP_NORMAL, -1, 1, VALUE_MIN));
    pending_items.push_back(make_point(OP_DIR, VALUE_MAX, -1, '0));
    // Extreme coefficients and translations so that both clamps fire; the tiny
    // coefficient times -1 checks that the shift floors toward minus infinity.
    pending_items.push_back(make_load(FWD_BASE + 0, VALUE_MAX));
    pending_items.push_back(make_load(FWD_BASE + 4, VALUE_MIN));
    pending_items.push_back(make_load(FWD_BASE + 8, 1));
    pending_items.push_back(make_load(FWD_TR_BASE + 0, VALUE_MAX));
    pending_items.push_back(make_load(FWD_TR_BASE + 1, VALUE_MIN));
    pending_items.push_back(make_load(FWD_TR_BASE + 2, -ONE));
    pending_items.push_back(make_point(OP_FWD, VALUE_MAX, VALUE_MAX, -1));
    pending_items.push_back(make_point(OP_FWD, '0, '0, '0));
    pending_items.push_back(make_point(OP_DIR, VALUE_MIN, VALUE_MIN, VALUE_MIN));
    // Loads past the end of the record and unknown operations must change nothing.
    pending_items.push_back(make_load(RECORD_WORDS, VALUE_MAX));
    pending_items.push_back(make_load(INDEX_TOP, VALUE_MIN));
    pending_items.push_back(make_point(OP_SPARE_FIRST, ONE, ONE, ONE));
    pending_items.push_back(make_point(OP_SPARE_LAST, VALUE_MIN, VALUE_MAX, ONE));
    // An asymmetric inverse matrix tells the plain and the transposed modes apart.
    pending_items.push_back(make_load(INV_BASE + 1, 2 * ONE));
    pending_items.push_back(make_load(INV_BASE + 5, -(ONE / 2)));
    pending_items.push_back(make_load(INV_TR_BASE + 0, ONE));
    pending_items.push_back(make_load(INV_TR_BASE + 2, VALUE_MIN));
    pending_items.push_back(make_point(OP_INV, ONE, ONE, ONE));
    pending_items.push_back(make_point(OP_NORMAL, ONE, ONE, ONE));
    // A negative point on top of the most negative translation clamps low.
    pending_items.push_back(make_point(OP_INV, '0, '0, -ONE));
    pending_items.push_back(make_point(OP_NORMAL, 3, -5, 7));
    drain_all();

    // Random part, in phases with different idling on each side. Between phases the
    // sender holds off until the pipeline is empty.
    for (phase = 0; phase < PHASES; phase++) begin
      push_idle_on = (phase % 2 == 1) || (phase == PHASES - 1);
      pop_idle_on  = (phase >= 2);
      for (k = 0; k < PHASE_ITEMS; k++) pending_items.push_back(random_item());
      drain_all();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      error_count++;
    end

    $display("Run covered %0d record loads and %0d transforms in all four modes,",
             load_count, transform_count);
    $display("of which %0d clamped, plus %0d dropped loads or unknown operations.",
             clamped_count, ignored_count);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/avfx_pkg.sv
design/avfx_front.sv
design/avfx_queue.sv
design/avfx_back.sv
design/affine_vertex_transform_core.sv
tb/tb.sv
